@@ rtl/gbs_pkg.sv @@
// shared types, constants and sequencer states for the greedy box suppression block
package gbs_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam logic [15:0] THR_RESET = 16'd32768;

    // one input word: a candidate box
    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic [15:0]        score;
        logic [7:0]         label;
        logic               set_end;
    } in_t;

    // one output word: a surviving box
    typedef struct packed {
        logic signed [15:0] kept_left;
        logic signed [15:0] kept_top;
        logic [14:0]        kept_width;
        logic [14:0]        kept_height;
        logic [15:0]        kept_score;
        logic [7:0]         kept_label;
        logic               final_box;
        logic               capacity_overflow;
    } out_t;

    // one entry of the box store
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [15:0]        score;
        logic [7:0]         label;
    } box_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RANK_RD,
        ST_RANK_CMP,
        ST_SUP_ORD,
        ST_SUP_BOX,
        ST_SUP_GEO,
        ST_MUL_INTER,
        ST_MUL_AREA_A,
        ST_MUL_AREA_B,
        ST_MUL_UNION,
        ST_CMP,
        ST_OUT_ORD,
        ST_OUT_BOX,
        ST_OUT_CHK,
        ST_OUT_WAIT
    } state_t;

endpackage

@@ rtl/greedy_box_suppression.sv @@
// greedy box suppression: box store, rank sort, pairwise overlap test, survivor output
// Loading accepts one box per cycle while in_valid is high; in_ready is high only while loading.
// Closing a set of n boxes: ranking makes one score compare per pair, each pair read from memory,
// suppression tests each ordered pair through one shared 31x16 multiplier, and output scans
// each sorted entry and hands out each survivor, waiting through any output stall.
// Reset (rst_n low, asynchronous) empties the store, clears overflow and sets the threshold to 0.5.
module greedy_box_suppression #(
    parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gbs_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output gbs_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);
    import gbs_pkg::*;

    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] N_MAX = CW'(MAX_BOXES);

    // control and datapath registers
    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic [15:0]          thr_reg;
    logic [MAX_BOXES-1:0] alive_reg, alive_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [CW-1:0]        rank_reg, rank_next;
    logic [CW-1:0]        surv_reg, surv_next;
    logic [CW-1:0]        emit_reg, emit_next;
    logic [IW-1:0]        oi_reg, oi_next;
    logic [IW-1:0]        oj_reg, oj_next;
    logic [14:0]          iw_reg, iw_next;
    logic [14:0]          ih_reg, ih_next;
    logic [29:0]          inter_reg, inter_next;
    logic [29:0]          area_a_reg, area_a_next;
    logic [29:0]          area_b_reg, area_b_next;
    logic [46:0]          prod_reg, prod_next;
    logic                 out_valid_reg, out_valid_next;
    out_t                 out_reg, out_next;

    // memories and their ports
    box_t          box_mem [MAX_BOXES];
    logic [IW-1:0] ord_mem [MAX_BOXES];
    box_t          box_rd_a, box_rd_b;
    logic [IW-1:0] ord_rd_a, ord_rd_b;
    logic          box_we, box_rd_en, ord_we, ord_rd_en;
    logic [IW-1:0] box_wr_addr, box_addr_a, box_addr_b;
    logic [IW-1:0] ord_wr_addr, ord_wr_data, ord_addr_a, ord_addr_b;
    box_t          box_wr_data;

    // shared signals
    logic          in_acc, out_acc, store_ok, beat, last_j, sup_done, is_final;
    logic [CW-1:0] rank_inc, cnt_inc, i_inc, j_inc, i_plus2;
    logic signed [17:0] la, lb, ra, rb, ta, tb, ba, bb, iw_s, ih_s;
    logic          iw_pos, ih_pos;
    logic [30:0]   mul_x, uni;
    logic [15:0]   mul_y;
    logic [46:0]   mul_p;
    logic          over_thr;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid_reg && out_ready;
    assign store_ok = (cnt_reg < N_MAX);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign i_inc    = i_reg + 1'b1;
    assign j_inc    = j_reg + 1'b1;
    assign i_plus2  = i_reg + CW'(2);
    assign last_j   = (j_inc == cnt_reg);
    assign sup_done = (i_plus2 >= cnt_reg);
    assign is_final = (emit_reg == surv_reg - 1'b1);

    // rank compare: b outranks a on higher score, or equal score and earlier arrival
    assign beat = (box_rd_b.score > box_rd_a.score)
               || ((box_rd_b.score == box_rd_a.score) && (j_reg < i_reg));
    assign rank_inc = rank_reg + CW'(beat);

    // overlap extents of the two boxes
    assign la = {{2{box_rd_a.left[15]}}, box_rd_a.left};
    assign lb = {{2{box_rd_b.left[15]}}, box_rd_b.left};
    assign ta = {{2{box_rd_a.top[15]}}, box_rd_a.top};
    assign tb = {{2{box_rd_b.top[15]}}, box_rd_b.top};
    assign ra = la + $signed({3'b000, box_rd_a.width});
    assign rb = lb + $signed({3'b000, box_rd_b.width});
    assign ba = ta + $signed({3'b000, box_rd_a.height});
    assign bb = tb + $signed({3'b000, box_rd_b.height});
    assign iw_s = ((ra < rb) ? ra : rb) - ((la > lb) ? la : lb);
    assign ih_s = ((ba < bb) ? ba : bb) - ((ta > tb) ? ta : tb);
    assign iw_pos = (iw_s > 18'sd0);
    assign ih_pos = (ih_s > 18'sd0);

    // shared multiplier operand select
    assign uni = {1'b0, area_a_reg} + {1'b0, area_b_reg} - {1'b0, inter_reg};
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_INTER:
            begin
                mul_x = {16'b0, iw_reg};
                mul_y = {1'b0, ih_reg};
            end
            ST_MUL_AREA_A:
            begin
                mul_x = {16'b0, box_rd_a.width};
                mul_y = {1'b0, box_rd_a.height};
            end
            ST_MUL_AREA_B:
            begin
                mul_x = {16'b0, box_rd_b.width};
                mul_y = {1'b0, box_rd_b.height};
            end
            default:
            begin
                mul_x = uni;
                mul_y = thr_reg;
            end
        endcase
    end
    assign mul_p    = {16'b0, mul_x} * {31'b0, mul_y};
    assign over_thr = ({1'b0, inter_reg, 16'b0} > prod_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (in_acc && in_data.set_end)
                    state_next = ST_RANK_RD;
            ST_RANK_RD:
                state_next = ST_RANK_CMP;
            ST_RANK_CMP:
                if (last_j && (i_inc == cnt_reg))
                    state_next = (cnt_reg < CW'(2)) ? ST_OUT_ORD : ST_SUP_ORD;
                else
                    state_next = ST_RANK_RD;
            ST_SUP_ORD:
                state_next = ST_SUP_BOX;
            ST_SUP_BOX:
                state_next = ST_SUP_GEO;
            ST_SUP_GEO:
                if (!alive_reg[oi_reg])
                    state_next = sup_done ? ST_OUT_ORD : ST_SUP_ORD;
                else if (alive_reg[oj_reg] && iw_pos && ih_pos)
                    state_next = ST_MUL_INTER;
                else if (last_j && sup_done)
                    state_next = ST_OUT_ORD;
                else
                    state_next = ST_SUP_ORD;
            ST_MUL_INTER:
                state_next = ST_MUL_AREA_A;
            ST_MUL_AREA_A:
                state_next = ST_MUL_AREA_B;
            ST_MUL_AREA_B:
                state_next = ST_MUL_UNION;
            ST_MUL_UNION:
                state_next = ST_CMP;
            ST_CMP:
                state_next = (last_j && sup_done) ? ST_OUT_ORD : ST_SUP_ORD;
            ST_OUT_ORD:
                state_next = ST_OUT_BOX;
            ST_OUT_BOX:
                state_next = ST_OUT_CHK;
            ST_OUT_CHK:
                state_next = alive_reg[oi_reg] ? ST_OUT_WAIT : ST_OUT_ORD;
            ST_OUT_WAIT:
                if (out_acc)
                    state_next = out_reg.final_box ? ST_LOAD : ST_OUT_ORD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        alive_next     = alive_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rank_next      = rank_reg;
        surv_next      = surv_reg;
        emit_next      = emit_reg;
        oi_next        = oi_reg;
        oj_next        = oj_reg;
        iw_next        = iw_reg;
        ih_next        = ih_reg;
        inter_next     = inter_reg;
        area_a_next    = area_a_reg;
        area_b_next    = area_b_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        box_we         = 1'b0;
        box_wr_addr    = cnt_reg[IW-1:0];
        box_wr_data    = '{left: in_data.box_left, top: in_data.box_top,
                           width: in_data.box_width, height: in_data.box_height,
                           score: in_data.score, label: in_data.label};
        box_rd_en      = 1'b0;
        box_addr_a     = i_reg[IW-1:0];
        box_addr_b     = j_reg[IW-1:0];
        ord_we         = 1'b0;
        ord_wr_addr    = rank_inc[IW-1:0];
        ord_wr_data    = i_reg[IW-1:0];
        ord_rd_en      = 1'b0;
        ord_addr_a     = i_reg[IW-1:0];
        ord_addr_b     = j_reg[IW-1:0];
        unique case (state_reg)
            ST_LOAD:
                if (in_acc)
                begin
                    if (store_ok)
                    begin
                        box_we                        = 1'b1;
                        alive_next[cnt_reg[IW-1:0]]   = 1'b1;
                        cnt_next                      = cnt_inc;
                    end
                    else
                        ovf_next = 1'b1;
                    if (in_data.set_end)
                    begin
                        i_next    = '0;
                        j_next    = '0;
                        rank_next = '0;
                        emit_next = '0;
                        surv_next = store_ok ? cnt_inc : cnt_reg;
                    end
                end
            ST_RANK_RD:
                box_rd_en = 1'b1;
            ST_RANK_CMP:
                if (last_j)
                begin
                    ord_we    = 1'b1;
                    rank_next = '0;
                    j_next    = '0;
                    i_next    = i_inc;
                    if (i_inc == cnt_reg)
                    begin
                        i_next = '0;
                        j_next = CW'(1);
                    end
                end
                else
                begin
                    rank_next = rank_inc;
                    j_next    = j_inc;
                end
            ST_SUP_ORD:
                ord_rd_en = 1'b1;
            ST_SUP_BOX:
            begin
                box_rd_en  = 1'b1;
                box_addr_a = ord_rd_a;
                box_addr_b = ord_rd_b;
                oi_next    = ord_rd_a;
                oj_next    = ord_rd_b;
            end
            ST_SUP_GEO:
            begin
                iw_next = iw_s[14:0];
                ih_next = ih_s[14:0];
                if (!alive_reg[oi_reg])
                begin
                    // a dropped box suppresses nothing: skip its row
                    i_next = sup_done ? '0 : i_inc;
                    j_next = i_plus2;
                end
                else if (!(alive_reg[oj_reg] && iw_pos && ih_pos))
                begin
                    if (last_j)
                    begin
                        i_next = sup_done ? '0 : i_inc;
                        j_next = i_plus2;
                    end
                    else
                        j_next = j_inc;
                end
            end
            ST_MUL_INTER:
                inter_next = mul_p[29:0];
            ST_MUL_AREA_A:
                area_a_next = mul_p[29:0];
            ST_MUL_AREA_B:
                area_b_next = mul_p[29:0];
            ST_MUL_UNION:
                prod_next = mul_p;
            ST_CMP:
            begin
                if (over_thr)
                begin
                    alive_next[oj_reg] = 1'b0;
                    surv_next          = surv_reg - 1'b1;
                end
                if (last_j)
                begin
                    i_next = sup_done ? '0 : i_inc;
                    j_next = i_plus2;
                end
                else
                    j_next = j_inc;
            end
            ST_OUT_ORD:
                ord_rd_en = 1'b1;
            ST_OUT_BOX:
            begin
                box_rd_en  = 1'b1;
                box_addr_a = ord_rd_a;
                oi_next    = ord_rd_a;
            end
            ST_OUT_CHK:
                if (alive_reg[oi_reg])
                begin
                    out_valid_next = 1'b1;
                    out_next = '{kept_left: box_rd_a.left, kept_top: box_rd_a.top,
                                 kept_width: box_rd_a.width, kept_height: box_rd_a.height,
                                 kept_score: box_rd_a.score, kept_label: box_rd_a.label,
                                 final_box: is_final, capacity_overflow: ovf_reg};
                end
                else
                    i_next = i_inc;
            ST_OUT_WAIT:
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    emit_next      = emit_reg + 1'b1;
                    i_next         = i_inc;
                    if (out_reg.final_box)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        alive_next = '0;
                    end
                end
            default:
            begin
            end
        endcase
    end

    // box store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (box_we)
            box_mem[box_wr_addr] <= box_wr_data;
        if (box_rd_en)
        begin
            box_rd_a <= box_mem[box_addr_a];
            box_rd_b <= box_mem[box_addr_b];
        end
    end

    // sorted order store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wr_addr] <= ord_wr_data;
        if (ord_rd_en)
        begin
            ord_rd_a <= ord_mem[ord_addr_a];
            ord_rd_b <= ord_mem[ord_addr_b];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            thr_reg       <= THR_RESET;
            alive_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            surv_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            alive_reg     <= alive_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rank_reg      <= rank_next;
            surv_reg      <= surv_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        oi_reg     <= oi_next;
        oj_reg     <= oj_next;
        iw_reg     <= iw_next;
        ih_reg     <= ih_next;
        inter_reg  <= inter_next;
        area_a_reg <= area_a_next;
        area_b_reg <= area_b_next;
        prod_reg   <= prod_next;
        out_reg    <= out_next;
    end

`ifndef ASSERT_OFF
    // no box is taken while a result is pending
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // survivor count never exceeds the stored count
    a_surv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (surv_reg <= cnt_reg))
        else $error("survivor count above stored count");

    // the final word returns the block to loading with an empty store
    a_final_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.final_box) |=> (in_ready && cnt_reg == '0))
        else $error("set not closed after final word");

    // a set holds at least one survivor whenever an entry is checked for output
    a_surv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT_CHK) |-> (surv_reg != '0))
        else $error("no survivor in a closed set");
`endif

endmodule
